// File: rtl/tmm_pkg.sv
// tmm_pkg: shared widths, constants and register codes for the trimmed-mean moisture unit
// no dependencies; imported by the top level and its property checker
`timescale 1ns / 1ps

package tmm_pkg;

	localparam int unsigned SAMPLE_W   = 10;
	localparam int unsigned Q8_W       = 15;
	localparam int unsigned DIV_W      = 25;
	localparam int unsigned WINDOW_DEF = 10;
	localparam int unsigned TRIM_DEF   = 2;
	localparam int unsigned APB_DW     = 32;
	localparam int unsigned APB_AW     = 3;

	localparam logic [Q8_W-1:0]     FULL_SCALE_Q8 = 15'd25600;
	localparam logic [SAMPLE_W-1:0] DRY_RESET     = 10'd800;
	localparam logic [SAMPLE_W-1:0] WET_RESET     = 10'd300;

	// register index codes, taken from paddr[2]
	localparam logic REG_DRY = 1'b0;
	localparam logic REG_WET = 1'b1;

endpackage

// File: rtl/tmm_ram.sv
// tmm_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps

module tmm_ram #(
	parameter int unsigned WIDTH = 10,
	parameter int unsigned DEPTH = 10
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/tmm_div.sv
// tmm_div: restoring divider, one quotient bit per cycle
// no dependencies; divisor must be non-zero
`timescale 1ns / 1ps

module tmm_div #(
	parameter int unsigned NUM_W = 25,
	parameter int unsigned DEN_W = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;

	logic [DEN_W:0] rem_sh;
	logic [DEN_W:0] rem_nx;
	logic           ge;

	assign rem_sh = {rem_q, quo_q[NUM_W-1]};
	assign ge     = rem_sh >= {1'b0, den_q};
	assign rem_nx = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(NUM_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (run_q) begin
			rem_q <= rem_nx[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

// File: rtl/trimmed_mean_moisture_percent_unit.sv
// trimmed_mean_moisture_percent_unit: trimmed mean of a sample window mapped to Q8 percent
// depends on tmm_pkg, tmm_ram, tmm_div; done is one cycle wide and cannot be stalled
// a sample that does not close the window is stored while busy stays low
// the closing sample raises busy, which stays high until done; the cost is the rank pass
// and one division of 25 quotient bits, which is skipped when the mapping is zero or the calibration is bad;
// async reset empties the window and loads calibration defaults
`timescale 1ns / 1ps

module trimmed_mean_moisture_percent_unit
	import tmm_pkg::*;
#(
	parameter int unsigned WINDOW = WINDOW_DEF,
	parameter int unsigned TRIM   = TRIM_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	output logic [APB_DW-1:0]   prdata,
	output logic                pready,
	// sample word in
	input  logic                start,
	input  logic [SAMPLE_W-1:0] sample,
	output logic                busy,
	// result word out
	output logic                done,
	output logic [SAMPLE_W-1:0] mean_value,
	output logic [Q8_W-1:0]     moisture_q8,
	output logic                cal_error
);

	// window geometry; an over-large trim falls back to keeping the middle value(s)
	localparam int unsigned AW    = $clog2(WINDOW);
	localparam int unsigned T_EFF = (2 * TRIM >= WINDOW) ? (WINDOW - 1) / 2 : TRIM;
	localparam int unsigned HI    = WINDOW - T_EFF;
	localparam int unsigned N_MID = HI - T_EFF;
	localparam int unsigned SUM_W = SAMPLE_W + AW;
	localparam logic [AW-1:0] LAST_IDX = AW'(WINDOW - 1);

	// mean by reciprocal multiply, exact over the whole sum range
	localparam int unsigned RECIP_SH = SUM_W + $clog2(N_MID);
	localparam int unsigned RECIP_W  = RECIP_SH + 1;
	localparam int unsigned MPROD_W  = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << RECIP_SH) + N_MID - 1) / N_MID);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_LDI    = 9'b000000010,
		S_GETI   = 9'b000000100,
		S_CMP    = 9'b000001000,
		S_MEAN   = 9'b000010000,
		S_MAP    = 9'b000100000,
		S_QSTART = 9'b001000000,
		S_QWAIT  = 9'b010000000,
		S_OUT    = 9'b100000000
	} state_t;

	state_t state_q;

	// calibration registers
	logic [SAMPLE_W-1:0] dry_q;
	logic [SAMPLE_W-1:0] wet_q;

	// window fill and rank pass
	logic [AW-1:0]       fill_q;
	logic [AW-1:0]       i_q;
	logic [AW-1:0]       j_q;
	logic [AW-1:0]       rank_q;
	logic [SAMPLE_W-1:0] vi_q;
	logic [SUM_W-1:0]    sum_q;

	// mapping and result
	logic [SAMPLE_W-1:0] mean_q;
	logic [DIV_W-1:0]    prod_q;
	logic [SAMPLE_W-1:0] den_q;
	logic                skip_q;
	logic                err_q;
	logic [Q8_W-1:0]     q8_q;

	logic                accept;
	logic                ram_we;
	logic [AW-1:0]       raddr;
	logic [SAMPLE_W-1:0] rdata;
	logic                less;
	logic [AW-1:0]       rank_nx;
	logic                keep;
	logic [MPROD_W-1:0]  mean_prod;
	logic                wet_gt;
	logic                den_zero;
	logic                pos;
	logic [SAMPLE_W-1:0] diff;
	logic [SAMPLE_W-1:0] span;
	logic                div_go;
	logic [DIV_W-1:0]    div_num;
	logic [SAMPLE_W-1:0] div_den;
	logic                div_done;
	logic [DIV_W-1:0]    div_quot;
	logic                cfg_wr;

	// ---------------------------------------------------------------
	// configuration port: zero-wait writes, low ten bits kept
	// ---------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dry_q <= DRY_RESET;
			wet_q <= WET_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_DRY) begin
				dry_q <= pwdata[SAMPLE_W-1:0];
			end else begin
				wet_q <= pwdata[SAMPLE_W-1:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_WET) ? APB_DW'(wet_q) : APB_DW'(dry_q);

	// ---------------------------------------------------------------
	// sample store: one word written per accepted sample
	// ---------------------------------------------------------------
	assign busy   = (state_q != S_IDLE);
	assign accept = start & ~busy;
	assign ram_we = accept;

	// read address: the pivot sample, then a sweep over the whole window
	always_comb begin
		case (state_q)
			S_LDI:   raddr = i_q;
			S_GETI:  raddr = '0;
			S_CMP:   raddr = j_q + AW'(1);
			default: raddr = i_q;
		endcase
	end

	tmm_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(WINDOW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_q),
		.wdata (sample),
		.raddr (raddr),
		.rdata (rdata)
	);

	// ---------------------------------------------------------------
	// rank pass: the shared comparator counts the samples ranked below the
	// pivot, ties broken by store position, so ranks form a permutation and
	// the pivot is summed when its rank lies in the central band
	// ---------------------------------------------------------------
	assign less    = (rdata < vi_q) | ((rdata == vi_q) & (j_q < i_q));
	assign rank_nx = rank_q + {{(AW-1){1'b0}}, less};
	assign keep    = (rank_nx >= AW'(T_EFF)) && ({1'b0, rank_nx} < (AW+1)'(HI));

	// central sum over the central count
	assign mean_prod = MPROD_W'(sum_q) * MPROD_W'(RECIP);

	// ---------------------------------------------------------------
	// two-point mapping; direction follows the sign of wet minus dry
	// ---------------------------------------------------------------
	assign wet_gt   = wet_q > dry_q;
	assign den_zero = (wet_q == dry_q);
	assign pos      = wet_gt ? (mean_q > dry_q) : (mean_q < dry_q);
	assign diff     = wet_gt ? (mean_q - dry_q) : (dry_q - mean_q);
	assign span     = wet_gt ? (wet_q - dry_q) : (dry_q - wet_q);

	// divider: scaled distance from dry over the calibration span
	assign div_go  = (state_q == S_QSTART) & ~skip_q;
	assign div_num = prod_q;
	assign div_den = den_q;

	tmm_div #(
		.NUM_W(DIV_W),
		.DEN_W(SAMPLE_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// ---------------------------------------------------------------
	// sequencer
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (fill_q == LAST_IDX) begin
							// window closed: start over and process it
							fill_q  <= '0;
							state_q <= S_LDI;
						end else begin
							fill_q <= fill_q + AW'(1);
						end
					end
				end
				S_LDI:   state_q <= S_GETI;
				S_GETI:  state_q <= S_CMP;
				S_CMP: begin
					if (j_q == LAST_IDX) begin
						state_q <= (i_q == LAST_IDX) ? S_MEAN : S_LDI;
					end
				end
				S_MEAN:   state_q <= S_MAP;
				S_MAP:    state_q <= S_QSTART;
				S_QSTART: state_q <= skip_q ? S_OUT : S_QWAIT;
				S_QWAIT: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT:   state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, all loaded before they are read
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start && (fill_q == LAST_IDX)) begin
					i_q   <= '0;
					sum_q <= '0;
				end
			end
			S_GETI: begin
				vi_q   <= rdata;
				j_q    <= '0;
				rank_q <= '0;
			end
			S_CMP: begin
				j_q    <= j_q + AW'(1);
				rank_q <= rank_nx;
				if (j_q == LAST_IDX) begin
					if (keep) begin
						sum_q <= sum_q + SUM_W'(vi_q);
					end
					i_q <= i_q + AW'(1);
				end
			end
			S_MEAN: begin
				mean_q <= mean_prod[RECIP_SH +: SAMPLE_W];
			end
			S_MAP: begin
				prod_q <= DIV_W'(diff) * DIV_W'(FULL_SCALE_Q8);
				den_q  <= span;
				// equal points or a mean on the dry side give zero
				skip_q <= den_zero | ~pos;
				err_q  <= den_zero;
			end
			S_QSTART: begin
				if (skip_q) begin
					q8_q <= '0;
				end
			end
			S_QWAIT: begin
				if (div_done) begin
					// saturate past the wet point
					q8_q <= (div_quot > DIV_W'(FULL_SCALE_Q8)) ? FULL_SCALE_Q8
						: div_quot[Q8_W-1:0];
				end
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------
	// result word
	// ---------------------------------------------------------------
	assign done        = (state_q == S_OUT);
	assign mean_value  = mean_q;
	assign moisture_q8 = q8_q;
	assign cal_error   = err_q;

endmodule

// File: rtl/tmm_props.sv
// tmm_props: port-level properties of the trimmed-mean moisture unit, with its bind
// depends on tmm_pkg; binds to trimmed_mean_moisture_percent_unit
`timescale 1ns / 1ps

module tmm_props
	import tmm_pkg::*;
(
	input logic            clk,
	input logic            arst_n,
	input logic            busy,
	input logic            done,
	input logic [Q8_W-1:0] moisture_q8,
	input logic            cal_error
);

	// a result only comes out of a window being processed
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe while idle");

	// the result strobe is never high twice in a row
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// busy only drops after the result word has gone out
	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done))
		else $error("processing ended without a result");

	// bad calibration forces a zero percentage
	a_cal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && cal_error) |-> (moisture_q8 == '0))
		else $error("calibration error with non-zero percentage");

	// percentage stays within full scale
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (moisture_q8 <= FULL_SCALE_Q8))
		else $error("percentage above full scale");

endmodule

bind trimmed_mean_moisture_percent_unit tmm_props u_props (
	.clk         (clk),
	.arst_n      (arst_n),
	.busy        (busy),
	.done        (done),
	.moisture_q8 (moisture_q8),
	.cal_error   (cal_error)
);
